/* rtl/gds_pkg.sv */
// gds_pkg: shared constants, types and the 5x8 font table for the glyph to display stream block
// no dependencies
package gds_pkg;

  // display commands
  localparam logic [7:0] OP_CASET = 8'h2a;
  localparam logic [7:0] OP_RASET = 8'h2b;
  localparam logic [7:0] OP_RAMWR = 8'h2c;
  localparam logic [7:0] OP_DATA  = 8'h00;

  // configuration register indexes
  localparam int CFG_INDEX_W = 1;
  localparam logic [CFG_INDEX_W-1:0] REG_FOREGROUND = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_BACKGROUND = 1'b1;
  localparam logic [15:0] FOREGROUND_RESET = 16'hffff;
  localparam logic [15:0] BACKGROUND_RESET = 16'h0000;

  localparam int GLYPH_COUNT_DEFAULT = 117;
  localparam int FONT_ENTRIES = 117;
  localparam int FONT_INDEX_W = $clog2(FONT_ENTRIES);
  localparam int FONT_COLS = 5;

  // word sequence of one glyph
  localparam int CMD_WORDS = 3;
  localparam int PIXEL_WORDS = 16;
  localparam int WORDS_PER_GLYPH = CMD_WORDS + PIXEL_WORDS;
  localparam int WORD_CNT_W = $clog2(WORDS_PER_GLYPH);
  localparam logic [WORD_CNT_W-1:0] WORD_CASET = WORD_CNT_W'(0);
  localparam logic [WORD_CNT_W-1:0] WORD_RASET = WORD_CNT_W'(1);
  localparam logic [WORD_CNT_W-1:0] WORD_RAMWR = WORD_CNT_W'(2);
  localparam logic [WORD_CNT_W-1:0] WORD_LAST  = WORD_CNT_W'(WORDS_PER_GLYPH - 1);

  // queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic [9:0] x;
    logic [9:0] y;
    logic [FONT_COLS-1:0][7:0] cols;  // cols[c] is column c, bit r is row r
  } glyph_entry_t;

  typedef struct packed {
    logic [7:0]  opcode;
    logic        is_command;
    logic [63:0] payload;
    logic [3:0]  payload_bytes;
    logic        last;
  } out_word_t;

  // one entry per glyph, column 0 in the top byte
  localparam logic [39:0] FONT_ROM [FONT_ENTRIES] = '{
    40'h0000000000, 40'h00004f0000, 40'h0007000700,
    40'h147f147f14, 40'h242a7f2a12, 40'h2313086462,
    40'h3649552250, 40'h0005030000, 40'h001c224100,
    40'h0041221c00, 40'h14083e0814, 40'h08083e0808,
    40'h0050300000, 40'h0808080808, 40'h0060600000,
    40'h2010080402, 40'h3e5149453e, 40'h00427f4000,
    40'h4261514946, 40'h2141454b31, 40'h1814127f10,
    40'h2745454539, 40'h3c4a494930, 40'h0171090503,
    40'h3649494936, 40'h064949291e, 40'h0036360000,
    40'h0056360000, 40'h0814224100, 40'h1414141414,
    40'h0041221408, 40'h0201510906, 40'h324979413e,
    40'h7e1111117e, 40'h7f49494936, 40'h3e41414122,
    40'h7f4141221c, 40'h7f49494941, 40'h7f09090901,
    40'h3e4149497a, 40'h7f0808087f, 40'h00417f4100,
    40'h2040413f01, 40'h7f08142241, 40'h7f40404040,
    40'h7f020c027f, 40'h7f0408107f, 40'h3e4141413e,
    40'h7f09090906, 40'h3e4151215e, 40'h7f09192946,
    40'h4649494931, 40'h01017f0101, 40'h3f4040403f,
    40'h1f2040201f, 40'h3f4038403f, 40'h6314081463,
    40'h0708700807, 40'h6151494543, 40'h007f414100,
    40'h0204081020, 40'h0041417f00, 40'h0402010204,
    40'h4040404040, 40'h0001020400, 40'h2054545478,
    40'h7f48444438, 40'h3844444420, 40'h384444487f,
    40'h3854545418, 40'h087e090102, 40'h0c5252523e,
    40'h7f08040478, 40'h00447d4000, 40'h2040443d00,
    40'h7f10284400, 40'h00417f4000, 40'h7c04180478,
    40'h7c08040478, 40'h3844444438, 40'h7c14141408,
    40'h081414187c, 40'h7c08040408, 40'h4854545420,
    40'h043f444020, 40'h3c4040207c, 40'h1c2040201c,
    40'h3c4030403c, 40'h4428102844, 40'h0c5050503c,
    40'h4464544c44, 40'h0008364100, 40'h00007f0000,
    40'h0041360800, 40'h0804081008, 40'h08082a1c08,
    40'h081c2a0808, 40'h04027f0204, 40'h10207f2010,
    40'h15167c1615, 40'h033b444444, 40'h03037c1414,
    40'h4428102844, 40'h08082a0808, 40'h384448302c,
    40'hf854545428, 40'h2854544420, 40'h3e49090906,
    40'h38444c5424, 40'h403f08081f, 40'h1f08083f40,
    40'h3c4a4a4a3c, 40'h5864046458, 40'h443c047c44,
    40'h3028102818, 40'h3028242830, 40'h081c08080e
  };

endpackage

/* rtl/glyph_to_display_stream_top.sv */
// glyph_to_display_stream_top: 5x8 font character generator producing a display command stream
// depends on gds_pkg, gds_front, gds_fifo, gds_back
//
// Each accepted glyph (x_pos, y_pos, glyph_index) yields 19 result words: a column-window
// command 0x2a and a row-window command 0x2b (big-endian start and start+7 in the low 32 bits
// of payload), a memory-write command 0x2c, then sixteen pixel words of four 16-bit pixels
// each, row by row, pixels low byte first, the first pixel in bits 63:48; last marks the
// sixteenth pixel word. Font columns 5 to 7 are padding and show the background colour, and
// glyph indexes at or past GLYPH_COUNT (or past the 117 stored entries) render blank.
// The back end sends one result word per cycle while the results are popped without stall;
// its word counter sets the sustained rate. The front end accepts one glyph per cycle while
// the two-entry queue is not full, so push can run ahead of the stream, and when the back
// end is free the first word of a glyph goes from the queue into the glyph register and
// then into the result register.
// Colours are read live while words are built; write them only while the block is idle.
module glyph_to_display_stream_top #(
  parameter int GLYPH_COUNT = gds_pkg::GLYPH_COUNT_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  // configuration write port
  input  logic                            cfg_we,
  input  logic [gds_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [15:0]                     cfg_data,
  // glyph input, queue style
  input  logic                            push,
  output logic                            full,
  input  logic [9:0]                      x_pos,
  input  logic [9:0]                      y_pos,
  input  logic [7:0]                      glyph_index,
  // result stream, queue style
  output logic                            empty,
  input  logic                            pop,
  output logic [7:0]                      opcode,
  output logic                            is_command,
  output logic [63:0]                     payload,
  output logic [3:0]                      payload_bytes,
  output logic                            last
);
  import gds_pkg::*;

  glyph_entry_t front_entry;
  glyph_entry_t q_head;
  logic         q_write;
  logic         q_read;
  logic         q_empty;
  out_word_t    out_word;

  // front: input transfer, range check and font lookup
  gds_front #(
    .GLYPH_COUNT(GLYPH_COUNT)
  ) u_front (
    .push        (push),
    .q_full      (full),
    .x_pos       (x_pos),
    .y_pos       (y_pos),
    .glyph_index (glyph_index),
    .q_write     (q_write),
    .q_data      (front_entry)
  );

  // decoupling queue, full is the input back-pressure
  gds_fifo u_fifo (
    .clk     (clk),
    .rst     (rst),
    .wr      (q_write),
    .wr_data (front_entry),
    .rd      (q_read),
    .rd_data (q_head),
    .full    (full),
    .q_empty (q_empty)
  );

  // back: word sequencer with its own result register
  gds_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_empty   (q_empty),
    .q_data    (q_head),
    .q_read    (q_read),
    .pop       (pop),
    .empty     (empty),
    .out_word  (out_word)
  );

  assign opcode        = out_word.opcode;
  assign is_command    = out_word.is_command;
  assign payload       = out_word.payload;
  assign payload_bytes = out_word.payload_bytes;
  assign last          = out_word.last;

endmodule

/* rtl/gds_front.sv */
// gds_front: input transfer and glyph classification, font lookup into a queue entry
// depends on gds_pkg
module gds_front #(
  parameter int GLYPH_COUNT = gds_pkg::GLYPH_COUNT_DEFAULT
) (
  input  logic                 push,
  input  logic                 q_full,
  input  logic [9:0]           x_pos,
  input  logic [9:0]           y_pos,
  input  logic [7:0]           glyph_index,
  output logic                 q_write,
  output gds_pkg::glyph_entry_t q_data
);
  import gds_pkg::*;

  logic        in_font;
  logic [39:0] rom_word;

  // indexes past the parameter or past the stored table render blank
  assign in_font = ({1'b0, glyph_index} < 9'(GLYPH_COUNT)) &&
                   (glyph_index < 8'(FONT_ENTRIES));
  assign rom_word = in_font ? FONT_ROM[glyph_index[FONT_INDEX_W-1:0]] : 40'h0;

  assign q_write = push && !q_full;

  always_comb begin
    q_data.x = x_pos;
    q_data.y = y_pos;
    for (int c = 0; c < FONT_COLS; c++) begin
      q_data.cols[c] = rom_word[39 - 8*c -: 8];
    end
  end

endmodule

/* rtl/gds_fifo.sv */
// gds_fifo: short queue of classified glyphs between front and back
// depends on gds_pkg
module gds_fifo (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  wr,
  input  gds_pkg::glyph_entry_t wr_data,
  input  logic                  rd,
  output gds_pkg::glyph_entry_t rd_data,
  output logic                  full,
  output logic                  q_empty
);
  import gds_pkg::*;

  glyph_entry_t       mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr;
  logic [QPTR_W-1:0]  rd_ptr;
  logic [QCNT_W-1:0]  count;

  assign full    = (count == QCNT_W'(QUEUE_DEPTH));
  assign q_empty = (count == '0);
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (rd) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (wr && !rd) begin
        count <= count + 1'b1;
      end else if (rd && !wr) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

endmodule

/* rtl/gds_back.sv */
// gds_back: colour registers, word sequencer and result register
// depends on gds_pkg
module gds_back (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [gds_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [15:0]                   cfg_data,
  input  logic                          q_empty,
  input  gds_pkg::glyph_entry_t         q_data,
  output logic                          q_read,
  input  logic                          pop,
  output logic                          empty,
  output gds_pkg::out_word_t            out_word
);
  import gds_pkg::*;

  logic [15:0]           fg_color;
  logic [15:0]           bg_color;
  glyph_entry_t          cur;
  logic                  cur_valid;
  logic [WORD_CNT_W-1:0] cnt;
  logic                  out_valid;
  logic                  gen_fire;
  out_word_t             word_next;
  logic [3:0]            pix_word;
  logic [2:0]            row;
  logic [7:0][7:0]       cols8;
  logic [2:0]            col;
  logic [15:0]           color;

  function automatic logic [63:0] window_payload(input logic [9:0] start);
    logic [15:0] s;
    s = 16'(start);
    return {32'h0, s, s + 16'd7};
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      fg_color <= FOREGROUND_RESET;
      bg_color <= BACKGROUND_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_FOREGROUND: fg_color <= cfg_data;
        REG_BACKGROUND: bg_color <= cfg_data;
        default: ;
      endcase
    end
  end

  assign gen_fire = cur_valid && (!out_valid || pop);
  assign q_read   = !q_empty && (!cur_valid || (gen_fire && cnt == WORD_LAST));
  assign empty    = !out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (q_read) begin
        cur_valid <= 1'b1;
        cnt       <= '0;
      end else if (gen_fire) begin
        cnt <= cnt + 1'b1;
        if (cnt == WORD_LAST) begin
          cur_valid <= 1'b0;
        end
      end
      if (gen_fire) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_read) begin
      cur <= q_data;
    end
    if (gen_fire) begin
      out_word <= word_next;
    end
  end

  // pixel words: two per row, four columns each, padding columns blank
  assign pix_word = 4'(cnt - WORD_CNT_W'(CMD_WORDS));
  assign row      = pix_word[3:1];
  assign cols8    = {24'h0, cur.cols};

  always_comb begin
    word_next.opcode        = OP_DATA;
    word_next.is_command    = 1'b0;
    word_next.payload       = '0;
    word_next.payload_bytes = 4'd8;
    word_next.last          = (pix_word == 4'(PIXEL_WORDS - 1));
    col   = '0;
    color = '0;
    case (cnt)
      WORD_CASET: begin
        word_next.opcode        = OP_CASET;
        word_next.is_command    = 1'b1;
        word_next.payload       = window_payload(cur.x);
        word_next.payload_bytes = 4'd4;
        word_next.last          = 1'b0;
      end
      WORD_RASET: begin
        word_next.opcode        = OP_RASET;
        word_next.is_command    = 1'b1;
        word_next.payload       = window_payload(cur.y);
        word_next.payload_bytes = 4'd4;
        word_next.last          = 1'b0;
      end
      WORD_RAMWR: begin
        word_next.opcode        = OP_RAMWR;
        word_next.is_command    = 1'b1;
        word_next.payload_bytes = 4'd0;
        word_next.last          = 1'b0;
      end
      default: begin
        for (int p = 0; p < 4; p++) begin
          col   = {pix_word[0], 2'(p)};
          color = cols8[col][row] ? fg_color : bg_color;
          word_next.payload[63 - 16*p -: 16] = {color[7:0], color[15:8]};
        end
      end
    endcase
  end

endmodule

/* rtl/gds_check.sv */
// gds_check: port-level checks of the result stream, bound to the top level
// depends on gds_pkg and glyph_to_display_stream_top
module gds_check (
  input logic        clk,
  input logic        rst,
  input logic        empty,
  input logic        pop,
  input logic [7:0]  opcode,
  input logic        is_command,
  input logic [63:0] payload,
  input logic [3:0]  payload_bytes,
  input logic        last
);
  import gds_pkg::*;

  // reset leaves no result waiting
  a_reset_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("result pending after reset");

  // a waiting result holds until its transfer
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(opcode) && $stable(payload) && $stable(last)))
    else $error("result changed while stalled");

  // command words carry a window or nothing, never the last mark
  a_cmd_shape: assert property (@(posedge clk) disable iff (rst)
    (!empty && is_command) |->
      (!last && ((opcode == OP_RAMWR && payload_bytes == 4'd0) ||
                 (opcode == OP_CASET && payload_bytes == 4'd4) ||
                 (opcode == OP_RASET && payload_bytes == 4'd4))))
    else $error("malformed command word");

  // pixel words are full data words
  a_pix_shape: assert property (@(posedge clk) disable iff (rst)
    (!empty && !is_command) |-> (opcode == OP_DATA && payload_bytes == 4'd8))
    else $error("malformed pixel word");

  // memory-write is followed directly by pixel data
  a_ramwr_next: assert property (@(posedge clk) disable iff (rst)
    (!empty && pop && is_command && opcode == OP_RAMWR) |=> (empty || !is_command))
    else $error("command after memory-write");

endmodule

bind glyph_to_display_stream_top gds_check u_check (.*);

/* verif/glyph_to_display_stream_top_test.sv */
// glyph_to_display_stream_top_test: self-checking bench for the 5x8 character generator
// drives glyph transfers and colour writes, predicts the 19-word command stream per glyph
// depends on gds_pkg and glyph_to_display_stream_top
module glyph_to_display_stream_top_test;
  import gds_pkg::*;

  localparam int GLYPHS = 117;
  localparam int STORED_GLYPHS = 117;
  localparam int CYCLE_LIMIT = 300000;
  localparam int PHASE_ITEMS = 42;
  localparam int PHASES = 6;
  localparam int REPORT_MAX = 10;

  // own copy of the font, column 0 in the top byte, bit r of a column is row r
  localparam logic [39:0] GLYPH_BITMAPS [STORED_GLYPHS] = '{
    40'h0000000000, 40'h00004f0000, 40'h0007000700,
    40'h147f147f14, 40'h242a7f2a12, 40'h2313086462,
    40'h3649552250, 40'h0005030000, 40'h001c224100,
    40'h0041221c00, 40'h14083e0814, 40'h08083e0808,
    40'h0050300000, 40'h0808080808, 40'h0060600000,
    40'h2010080402, 40'h3e5149453e, 40'h00427f4000,
    40'h4261514946, 40'h2141454b31, 40'h1814127f10,
    40'h2745454539, 40'h3c4a494930, 40'h0171090503,
    40'h3649494936, 40'h064949291e, 40'h0036360000,
    40'h0056360000, 40'h0814224100, 40'h1414141414,
    40'h0041221408, 40'h0201510906, 40'h324979413e,
    40'h7e1111117e, 40'h7f49494936, 40'h3e41414122,
    40'h7f4141221c, 40'h7f49494941, 40'h7f09090901,
    40'h3e4149497a, 40'h7f0808087f, 40'h00417f4100,
    40'h2040413f01, 40'h7f08142241, 40'h7f40404040,
    40'h7f020c027f, 40'h7f0408107f, 40'h3e4141413e,
    40'h7f09090906, 40'h3e4151215e, 40'h7f09192946,
    40'h4649494931, 40'h01017f0101, 40'h3f4040403f,
    40'h1f2040201f, 40'h3f4038403f, 40'h6314081463,
    40'h0708700807, 40'h6151494543, 40'h007f414100,
    40'h0204081020, 40'h0041417f00, 40'h0402010204,
    40'h4040404040, 40'h0001020400, 40'h2054545478,
    40'h7f48444438, 40'h3844444420, 40'h384444487f,
    40'h3854545418, 40'h087e090102, 40'h0c5252523e,
    40'h7f08040478, 40'h00447d4000, 40'h2040443d00,
    40'h7f10284400, 40'h00417f4000, 40'h7c04180478,
    40'h7c08040478, 40'h3844444438, 40'h7c14141408,
    40'h081414187c, 40'h7c08040408, 40'h4854545420,
    40'h043f444020, 40'h3c4040207c, 40'h1c2040201c,
    40'h3c4030403c, 40'h4428102844, 40'h0c5050503c,
    40'h4464544c44, 40'h0008364100, 40'h00007f0000,
    40'h0041360800, 40'h0804081008, 40'h08082a1c08,
    40'h081c2a0808, 40'h04027f0204, 40'h10207f2010,
    40'h15167c1615, 40'h033b444444, 40'h03037c1414,
    40'h4428102844, 40'h08082a0808, 40'h384448302c,
    40'hf854545428, 40'h2854544420, 40'h3e49090906,
    40'h38444c5424, 40'h403f08081f, 40'h1f08083f40,
    40'h3c4a4a4a3c, 40'h5864046458, 40'h443c047c44,
    40'h3028102818, 40'h3028242830, 40'h081c08080e
  };

  // directed glyph; when hand_checked is set the stream is given by the window words
  // and one pixel word repeated sixteen times (blank cells under reset colours)
  typedef struct packed {
    logic [9:0]  x;
    logic [9:0]  y;
    logic [7:0]  glyph;
    logic        hand_checked;
    logic [31:0] col_window;
    logic [31:0] row_window;
    logic [63:0] pixels;
  } glyph_case_t;

  localparam int DIRECTED_COUNT = 20;
  localparam glyph_case_t DIRECTED [DIRECTED_COUNT] = '{
    // space at the origin
    '{10'd0,    10'd0,    8'd0,   1'b1, 32'h0000_0007, 32'h0000_0007, 64'd0},
    // far corner, top index
    '{10'd1023, 10'd1023, 8'd255, 1'b1, 32'h03ff_0406, 32'h03ff_0406, 64'd0},
    // first index past the font
    '{10'd0,    10'd1023, 8'd117, 1'b1, 32'h0000_0007, 32'h03ff_0406, 64'd0},
    '{10'd1023, 10'd0,    8'd200, 1'b1, 32'h03ff_0406, 32'h0000_0007, 64'd0},
    '{10'h155,  10'h2aa,  8'haa,  1'b1, 32'h0155_015c, 32'h02aa_02b1, 64'd0},
    '{10'd9,    10'd1000, 8'h7f,  1'b1, 32'h0009_0010, 32'h03e8_03ef, 64'd0},
    '{10'd640,  10'd480,  8'h80,  1'b1, 32'h0280_0287, 32'h01e0_01e7, 64'd0},
    '{10'd1023, 10'd1016, 8'd0,   1'b1, 32'h03ff_0406, 32'h03f8_03ff, 64'd0},
    '{10'h2aa,  10'h155,  8'h55,  1'b0, 32'd0, 32'd0, 64'd0},
    // last stored entry
    '{10'd1016, 10'd1016, 8'd116, 1'b0, 32'd0, 32'd0, 64'd0},
    // glyph with bit 7 set in a column, drawn in row 7
    '{10'd8,    10'd16,   8'd105, 1'b0, 32'd0, 32'd0, 64'd0},
    '{10'd1,    10'd2,    8'd1,   1'b0, 32'd0, 32'd0, 64'd0},
    '{10'd100,  10'd200,  8'd3,   1'b0, 32'd0, 32'd0, 64'd0},
    '{10'd1017, 10'd3,    8'd32,  1'b0, 32'd0, 32'd0, 64'd0},
    '{10'd500,  10'd7,    8'd64,  1'b0, 32'd0, 32'd0, 64'd0},
    '{10'd33,   10'd44,   8'd40,  1'b0, 32'd0, 32'd0, 64'd0},
    '{10'd255,  10'd256,  8'd99,  1'b0, 32'd0, 32'd0, 64'd0},
    '{10'd511,  10'd512,  8'd113, 1'b0, 32'd0, 32'd0, 64'd0},
    '{10'd768,  10'd1,    8'd16,  1'b0, 32'd0, 32'd0, 64'd0},
    '{10'd3,    10'd900,  8'd58,  1'b0, 32'd0, 32'd0, 64'd0}
  };

  logic clk;
  logic rst;
  logic cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [15:0] cfg_data;
  logic push;
  logic full;
  logic [9:0] x_pos;
  logic [9:0] y_pos;
  logic [7:0] glyph_index;
  logic empty;
  logic pop;
  logic [7:0] opcode;
  logic is_command;
  logic [63:0] payload;
  logic [3:0] payload_bytes;
  logic last;

  out_word_t pending_words[$];
  logic [15:0] fg_color;
  logic [15:0] bg_color;
  bit calm;
  int errors;
  int words_seen;
  int cycles;
  int stall_left;

  glyph_to_display_stream_top #(
    .GLYPH_COUNT(GLYPHS)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .push(push),
    .full(full),
    .x_pos(x_pos),
    .y_pos(y_pos),
    .glyph_index(glyph_index),
    .empty(empty),
    .pop(pop),
    .opcode(opcode),
    .is_command(is_command),
    .payload(payload),
    .payload_bytes(payload_bytes),
    .last(last)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic void queue_word(input logic [7:0] op, input logic cmd,
                                     input logic [63:0] data, input logic [3:0] nbytes,
                                     input logic fin);
    out_word_t w;
    w.opcode = op;
    w.is_command = cmd;
    w.payload = data;
    w.payload_bytes = nbytes;
    w.last = fin;
    pending_words.push_back(w);
  endfunction

  // window word: start and start+7, big-endian, in the low 32 bits
  function automatic logic [31:0] window_of(input logic [9:0] start);
    logic [15:0] s;
    s = 16'(start);
    return {s, 16'(s + 16'd7)};
  endfunction

  // expected stream of one glyph under the current colours
  function automatic void render_glyph(input logic [9:0] x, input logic [9:0] y,
                                       input logic [7:0] g);
    logic [7:0] cols [8];
    logic [63:0] word;
    logic [15:0] color;
    int idx;
    for (int c = 0; c < 8; c++) cols[c] = 8'd0;
    // indexes past the font leave every column clear
    if (int'(g) < GLYPHS && int'(g) < STORED_GLYPHS)
      for (int c = 0; c < FONT_COLS; c++) cols[c] = GLYPH_BITMAPS[g][39 - 8*c -: 8];
    queue_word(OP_CASET, 1'b1, {32'd0, window_of(x)}, 4'd4, 1'b0);
    queue_word(OP_RASET, 1'b1, {32'd0, window_of(y)}, 4'd4, 1'b0);
    queue_word(OP_RAMWR, 1'b1, 64'd0, 4'd0, 1'b0);
    for (int w = 0; w < PIXEL_WORDS; w++) begin
      word = 64'd0;
      for (int p = 0; p < 4; p++) begin
        idx = w * 4 + p;
        color = cols[idx % 8][idx / 8] ? fg_color : bg_color;
        // each pixel goes low byte first
        word = {word[47:0], color[7:0], color[15:8]};
      end
      queue_word(OP_DATA, 1'b0, word, 4'd8, w == PIXEL_WORDS - 1);
    end
  endfunction

  function automatic void queue_hand_checked(input glyph_case_t gc);
    queue_word(OP_CASET, 1'b1, {32'd0, gc.col_window}, 4'd4, 1'b0);
    queue_word(OP_RASET, 1'b1, {32'd0, gc.row_window}, 4'd4, 1'b0);
    queue_word(OP_RAMWR, 1'b1, 64'd0, 4'd0, 1'b0);
    for (int w = 0; w < PIXEL_WORDS; w++)
      queue_word(OP_DATA, 1'b0, gc.pixels, 4'd8, w == PIXEL_WORDS - 1);
  endfunction

  function automatic void flag_mismatch(input string what, input logic [63:0] want,
                                        input logic [63:0] got);
    errors++;
    if (errors <= REPORT_MAX)
      $display("mismatch on %s at word %0d: expected %h, got %h", what, words_seen, want, got);
  endfunction

  // one transfer on the result side, compared field by field with the oldest expectation
  task automatic check_result();
    out_word_t want;
    if (pending_words.size() == 0) begin
      flag_mismatch("unexpected result payload", 64'd0, payload);
    end else begin
      want = pending_words.pop_front();
      if (opcode !== want.opcode) flag_mismatch("opcode", 64'(want.opcode), 64'(opcode));
      if (is_command !== want.is_command)
        flag_mismatch("is_command", 64'(want.is_command), 64'(is_command));
      if (payload !== want.payload) flag_mismatch("payload", want.payload, payload);
      if (payload_bytes !== want.payload_bytes)
        flag_mismatch("payload_bytes", 64'(want.payload_bytes), 64'(payload_bytes));
      if (last !== want.last) flag_mismatch("last", 64'(want.last), 64'(last));
    end
    words_seen++;
  endtask

  // result side: check every transfer, stall in random bursts unless calm
  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
      stall_left = 0;
    end else begin
      if (pop && !empty) check_result();
      if (stall_left > 0) begin
        pop <= 1'b0;
        stall_left--;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        pop <= 1'b0;
        stall_left = $urandom_range(1, 6) - 1;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d words outstanding", cycles, pending_words.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  // offer one glyph and hold it until the transfer
  task automatic send_glyph(input logic [9:0] x, input logic [9:0] y, input logic [7:0] g);
    if (!calm && $urandom_range(0, 4) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    push <= 1'b1;
    x_pos <= x;
    y_pos <= y;
    glyph_index <= g;
    @(posedge clk);
    while (full) @(posedge clk);
  endtask

  // colours may only change while nothing is in flight
  task automatic wait_drained();
    push <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_colors(input logic [15:0] fg, input logic [15:0] bg);
    cfg_we <= 1'b1;
    cfg_index <= REG_FOREGROUND;
    cfg_data <= fg;
    @(posedge clk);
    fg_color = fg;
    cfg_index <= REG_BACKGROUND;
    cfg_data <= bg;
    @(posedge clk);
    bg_color = bg;
    cfg_we <= 1'b0;
  endtask

  // coordinates: mostly anywhere, sometimes pinned to an edge of the range
  function automatic logic [9:0] pick_coord();
    case ($urandom_range(0, 9))
      0: return 10'd0;
      1: return 10'd1023;
      default: return 10'($urandom_range(0, 1023));
    endcase
  endfunction

  task automatic random_glyphs(input int count);
    logic [9:0] x;
    logic [9:0] y;
    logic [7:0] g;
    repeat (count) begin
      x = pick_coord();
      y = pick_coord();
      // mostly real font entries, the rest past the table
      if ($urandom_range(0, 7) == 0) g = 8'($urandom_range(GLYPHS, 255));
      else g = 8'($urandom_range(0, GLYPHS - 1));
      send_glyph(x, y, g);
      render_glyph(x, y, g);
    end
  endtask

  initial begin
    logic [15:0] fg;
    logic [15:0] bg;
    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_index <= REG_FOREGROUND;
    cfg_data <= 16'd0;
    push <= 1'b0;
    x_pos <= 10'd0;
    y_pos <= 10'd0;
    glyph_index <= 8'd0;
    fg_color = FOREGROUND_RESET;
    bg_color = BACKGROUND_RESET;
    calm = 1'b0;
    errors = 0;
    words_seen = 0;
    cycles = 0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // directed glyphs under the reset colours
    for (int i = 0; i < DIRECTED_COUNT; i++) begin
      send_glyph(DIRECTED[i].x, DIRECTED[i].y, DIRECTED[i].glyph);
      if (DIRECTED[i].hand_checked) queue_hand_checked(DIRECTED[i]);
      else render_glyph(DIRECTED[i].x, DIRECTED[i].y, DIRECTED[i].glyph);
    end
    wait_drained();

    // random glyphs, one colour setting per phase; the last phase runs without idling
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: begin fg = 16'h0000; bg = 16'hffff; end
        1: begin fg = 16'h12ab; bg = 16'hcd34; end
        2: begin fg = 16'hffff; bg = 16'hffff; end
        3: begin fg = 16'h0000; bg = 16'h0000; end
        4: begin fg = 16'($urandom); bg = 16'($urandom); end
        default: begin fg = 16'hf81f; bg = 16'h07e0; end
      endcase
      write_colors(fg, bg);
      if (ph == PHASES - 1) calm = 1'b1;
      random_glyphs(PHASE_ITEMS);
      wait_drained();
    end

    // room for any stray word after the stream has drained
    repeat (40) @(posedge clk);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
